// ----- design/ccp_pkg.sv -----
// Package for the Cache-Control header parser: state encodings, name table
// and character class helpers. No dependencies.
package ccp_pkg;

    localparam int NameCount = 11;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_NAME = 2'd1,
        PH_ARG  = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        AS_START  = 3'd0,
        AS_TOKEN  = 3'd1,
        AS_IN     = 3'd2,
        AS_ESC    = 3'd3,
        AS_CLOSED = 3'd4,
        AS_BAD    = 3'd5
    } t_arg_state;

    typedef enum logic [2:0] {
        DS_START  = 3'd0,
        DS_TOKEN  = 3'd1,
        DS_OPEN   = 3'd2,
        DS_IN     = 3'd3,
        DS_ESC    = 3'd4,
        DS_CLOSED = 3'd5,
        DS_BAD    = 3'd6
    } t_delta_state;

    localparam logic [7:0] ChTilde = 8'h7e;
    localparam logic [7:0] ChBacktick = 8'h60;

    // Known name lengths, indexed by candidate bit
    function automatic logic [4:0] name_len(input int idx);
        logic [4:0] l;
        unique case (idx)
            0: l = 5'd8;
            1: l = 5'd8;
            2: l = 5'd15;
            3: l = 5'd16;
            4: l = 5'd7;
            5: l = 5'd6;
            6: l = 5'd9;
            7: l = 5'd7;
            8: l = 5'd8;
            9: l = 5'd22;
            default: l = 5'd14;
        endcase
        return l;
    endfunction

    // Expected lowercase character of name idx at position pos (0 if past end)
    function automatic logic [7:0] name_char(input int idx, input logic [4:0] pos);
        logic [8*22-1:0] s;
        logic [4:0] len;
        logic [7:0] ch;
        len = name_len(idx);
        unique case (idx)
            0: s = {"no-store", {14{8'h00}}};
            1: s = {"no-cache", {14{8'h00}}};
            2: s = {"must-revalidate", {7{8'h00}}};
            3: s = {"proxy-revalidate", {6{8'h00}}};
            4: s = {"private", {15{8'h00}}};
            5: s = {"public", {16{8'h00}}};
            6: s = {"immutable", {13{8'h00}}};
            7: s = {"max-age", {15{8'h00}}};
            8: s = {"s-maxage", {14{8'h00}}};
            9: s = "stale-while-revalidate";
            default: s = {"stale-if-error", {8{8'h00}}};
        endcase
        if (pos < len) ch = s[8*(21 - int'(pos)) +: 8];
        else ch = 8'h00;
        return ch;
    endfunction

    function automatic logic is_tchar(input logic [7:0] c);
        logic r;
        r = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
            c == "!" || c == "#" || c == "$" || c == "%" || c == "&" || c == 8'h27 ||
            c == "*" || c == "+" || c == "-" || c == "." || c == "^" || c == "_" ||
            c == ChBacktick || c == "|" || c == ChTilde;
        return r;
    endfunction

endpackage

// ----- design/cache_control_header_parser.sv -----
// Top level of the Cache-Control header parser: one byte per item, one
// result item per header value. Depends on ccp_pkg.
//
// Takes one header-value byte per cycle and emits the parsed directive flags
// and four delta-seconds values (first occurrence only, saturating at
// 2^DELTA_WIDTH-1) from an output register loaded when the item marked last
// is accepted. Every byte is handled by one registered pass through the
// splitter, name matcher, argument checkers and a multiply-by-ten
// accumulator, so the block takes one item per cycle; a result waiting in
// the output register stalls input only while i_ready is low.
module cache_control_header_parser #(
    parameter int DELTA_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [7:0]             i_char_byte,
    input  logic                   i_last,
    input  logic                   i_no_byte,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [6:0]             o_directive_flags,
    output logic [DELTA_WIDTH-1:0] o_max_age_secs,
    output logic                   o_max_age_ok,
    output logic [DELTA_WIDTH-1:0] o_shared_max_age_secs,
    output logic                   o_shared_max_age_ok,
    output logic [DELTA_WIDTH-1:0] o_revalidate_window_secs,
    output logic                   o_revalidate_window_ok,
    output logic [DELTA_WIDTH-1:0] o_error_window_secs,
    output logic                   o_error_window_ok
);
    import ccp_pkg::*;

    localparam logic [DELTA_WIDTH-1:0] DeltaMax = '1;
    // acc*10 + d fits while acc <= (DeltaMax - d) / 10, which is DivQ for
    // d <= DivR and DivQ - 1 above it
    localparam logic [DELTA_WIDTH-1:0] DivQ = DeltaMax / 10;
    localparam logic [DELTA_WIDTH-1:0] DivQLess = DivQ - DELTA_WIDTH'(1);
    localparam logic [3:0] DivR = 4'(DeltaMax % 10);

    logic r_in_q, r_esc;
    t_phase r_phase;
    logic [4:0] r_pos;
    logic [NameCount-1:0] r_cand;
    logic r_pend;
    t_arg_state r_as;
    t_delta_state r_ds;
    logic [DELTA_WIDTH-1:0] r_acc;
    logic [3:0] r_seen, r_dvalid;
    logic [6:0] r_flags;
    logic [DELTA_WIDTH-1:0] r_dres [4];

    logic [6:0] r_o_flags;
    logic [DELTA_WIDTH-1:0] r_o_secs [4];
    logic [3:0] r_o_ok;
    logic r_o_valid;

    logic acc;
    assign o_ready = !r_o_valid || i_ready;
    assign acc = i_valid && o_ready;

    // per-byte state after feeding this item and closing
    logic n_in_q, n_esc;
    t_phase n_phase;
    logic [4:0] n_pos;
    logic [NameCount-1:0] n_cand;
    logic n_pend;
    t_arg_state n_as;
    t_delta_state n_ds;
    logic [DELTA_WIDTH-1:0] n_acc;
    logic [3:0] n_seen, n_dvalid;
    logic [6:0] n_flags;
    logic [DELTA_WIDTH-1:0] n_dres [4];

    // directive state after the byte, before any close
    t_phase m_phase;
    logic [4:0] m_pos;
    logic [NameCount-1:0] m_cand;
    logic m_pend;
    t_arg_state m_as;
    t_delta_state m_ds;
    logic [DELTA_WIDTH-1:0] m_acc;

    logic [7:0] c, fc, lc, b;
    logic sep, ws, do_feed, fin, bws, bd, dig;
    logic [NameCount-1:0] r_exact, m_exact, match;
    logic has_arg, arg_ok, delta_ok;
    logic [DELTA_WIDTH-1:0] d, thr, s_acc;
    t_arg_state s_as;
    t_delta_state s_ds;
    logic [3:0] dsum;

    // full-length name matches before and after this byte
    always_comb begin
        r_exact = '0;
        m_exact = '0;
        for (int i = 0; i < NameCount; i++) begin
            r_exact[i] = r_cand[i] && (name_len(i) == r_pos);
            m_exact[i] = m_cand[i] && (name_len(i) == m_pos);
        end
    end

    // splitter, trimming and the byte (after any pending space) into matcher or checkers
    always_comb begin
        c = i_char_byte;
        ws = (c == " " || c == 8'h09);
        n_in_q = r_in_q; n_esc = r_esc;
        m_phase = r_phase; m_pos = r_pos; m_cand = r_cand; m_pend = r_pend;
        m_as = r_as; m_ds = r_ds; m_acc = r_acc;
        sep = 1'b0; do_feed = 1'b0; fc = c; lc = 8'h00;
        s_as = r_as; s_ds = r_ds; s_acc = r_acc;
        b = 8'h00; bws = 1'b0; bd = 1'b0; dig = 1'b0; dsum = '0; d = '0; thr = '0;

        if (!i_no_byte) begin
            // quote-aware comma split
            if (r_in_q) begin
                if (r_esc) n_esc = 1'b0;
                else if (c == "\\") n_esc = 1'b1;
                else if (c == "\"") n_in_q = 1'b0;
            end else if (c == "\"") n_in_q = 1'b1;
            else if (c == ",") sep = 1'b1;

            if (sep) begin
                // directive closes below from the unchanged state
            end else if (r_phase == PH_LEAD) begin
                if (!ws) begin
                    m_phase = PH_NAME;
                    do_feed = 1'b1;
                end
            end else if (ws) m_pend = 1'b1;
            else begin
                do_feed = 1'b1;
                if (r_pend) begin
                    m_pend = 1'b0;
                    if (r_phase == PH_NAME) m_cand = '0;
                    else fc = " ";
                end
            end
        end

        if (do_feed) begin
            if (m_phase == PH_NAME) begin
                if (c == "=") begin
                    m_cand = (r_pend) ? '0 : r_exact;
                    m_phase = PH_ARG;
                end else begin
                    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                    for (int i = 0; i < NameCount; i++)
                        if (r_pos >= name_len(i) || name_char(i, r_pos) != lc)
                            m_cand[i] = 1'b0;
                    if (r_pos < 5'd31) m_pos = r_pos + 5'd1;
                end
            end else begin
                // a pending space goes through the checkers first, then the byte
                for (int p = 0; p < 2; p++) begin
                    if (p == 1 || fc == " ") begin
                        b = (p == 0) ? 8'h20 : c;
                        bws = (b == " " || b == 8'h09);
                        bd = (b >= "0" && b <= "9");
                        unique case (s_as)
                            AS_START: s_as = (b == "\"") ? AS_IN :
                                (is_tchar(b) ? AS_TOKEN : AS_BAD);
                            AS_TOKEN: s_as = is_tchar(b) ? AS_TOKEN : AS_BAD;
                            AS_IN: begin
                                if (b == "\\") s_as = AS_ESC;
                                else if (b == "\"") s_as = AS_CLOSED;
                                else if ((b < 8'h20 && !bws) || b == 8'h7f) s_as = AS_BAD;
                            end
                            AS_ESC: s_as = ((b < 8'h21 && !bws) || b == 8'h7f) ?
                                AS_BAD : AS_IN;
                            default: s_as = AS_BAD;
                        endcase
                        dig = 1'b0;
                        unique case (s_ds)
                            DS_START: begin
                                if (bd) begin dig = 1'b1; s_ds = DS_TOKEN; end
                                else s_ds = (b == "\"") ? DS_OPEN : DS_BAD;
                            end
                            DS_TOKEN: if (bd) dig = 1'b1; else s_ds = DS_BAD;
                            DS_OPEN, DS_IN: begin
                                if (bd) begin dig = 1'b1; s_ds = DS_IN; end
                                else if (b == "\\") s_ds = DS_ESC;
                                else if (b == "\"" && s_ds == DS_IN) s_ds = DS_CLOSED;
                                else s_ds = DS_BAD;
                            end
                            DS_ESC: if (bd) begin dig = 1'b1; s_ds = DS_IN; end
                                else s_ds = DS_BAD;
                            default: s_ds = DS_BAD;
                        endcase
                        // a space never is a digit, so at most one accumulate
                        if (dig) begin
                            dsum = b[3:0];
                            d = DELTA_WIDTH'(dsum);
                            thr = (dsum <= DivR) ? DivQ : DivQLess;
                            if (s_acc > thr) s_acc = DeltaMax;
                            else s_acc = (s_acc << 3) + (s_acc << 1) + d;
                        end
                    end
                end
                m_as = s_as; m_ds = s_ds; m_acc = s_acc;
            end
        end
    end

    // close the current directive on a comma or at the end of the value
    always_comb begin
        fin = sep || i_last;
        n_phase = m_phase; n_pos = m_pos; n_cand = m_cand; n_pend = m_pend;
        n_as = m_as; n_ds = m_ds; n_acc = m_acc;
        n_seen = r_seen; n_dvalid = r_dvalid; n_flags = r_flags;
        for (int k = 0; k < 4; k++) n_dres[k] = r_dres[k];
        has_arg = 1'b0; match = '0; arg_ok = 1'b0; delta_ok = 1'b0;

        if (fin) begin
            if (m_phase != PH_LEAD) begin
                has_arg = (m_phase == PH_ARG);
                match = has_arg ? m_cand : m_exact;
                arg_ok = (m_as == AS_TOKEN || m_as == AS_CLOSED);
                delta_ok = has_arg && (m_ds == DS_TOKEN || m_ds == DS_CLOSED);
                for (int i = 0; i < 7; i++)
                    if (match[i] && (!has_arg || ((i == 1 || i == 4) && arg_ok)))
                        n_flags[i] = 1'b1;
                for (int i = 0; i < 4; i++)
                    if (match[i+7] && !r_seen[i]) begin
                        n_seen[i] = 1'b1;
                        if (delta_ok) begin
                            n_dres[i] = m_acc;
                            n_dvalid[i] = 1'b1;
                        end
                    end
            end
            n_phase = PH_LEAD; n_pos = '0; n_cand = '1; n_pend = 1'b0;
            n_as = AS_START; n_ds = DS_START; n_acc = '0;
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_q <= 1'b0; r_esc <= 1'b0; r_phase <= PH_LEAD; r_pos <= '0;
            r_cand <= '1; r_pend <= 1'b0; r_as <= AS_START; r_ds <= DS_START;
            r_acc <= '0; r_seen <= '0; r_dvalid <= '0; r_flags <= '0;
            for (int k = 0; k < 4; k++) r_dres[k] <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= (acc && i_last) || (r_o_valid && !i_ready);
            if (acc) begin
                if (i_last) begin
                    r_o_flags <= n_flags;
                    r_o_ok <= n_dvalid;
                    for (int k = 0; k < 4; k++)
                        r_o_secs[k] <= n_dvalid[k] ? n_dres[k] : '0;
                    r_in_q <= 1'b0; r_esc <= 1'b0; r_phase <= PH_LEAD; r_pos <= '0;
                    r_cand <= '1; r_pend <= 1'b0; r_as <= AS_START; r_ds <= DS_START;
                    r_acc <= '0; r_seen <= '0; r_dvalid <= '0; r_flags <= '0;
                    for (int k = 0; k < 4; k++) r_dres[k] <= '0;
                end else begin
                    r_in_q <= n_in_q; r_esc <= n_esc; r_phase <= n_phase; r_pos <= n_pos;
                    r_cand <= n_cand; r_pend <= n_pend; r_as <= n_as; r_ds <= n_ds;
                    r_acc <= n_acc; r_seen <= n_seen; r_dvalid <= n_dvalid;
                    r_flags <= n_flags;
                    for (int k = 0; k < 4; k++) r_dres[k] <= n_dres[k];
                end
            end
        end
    end

    assign o_valid = r_o_valid;
    assign o_directive_flags = r_o_flags;
    assign o_max_age_secs = r_o_secs[0];
    assign o_max_age_ok = r_o_ok[0];
    assign o_shared_max_age_secs = r_o_secs[1];
    assign o_shared_max_age_ok = r_o_ok[1];
    assign o_revalidate_window_secs = r_o_secs[2];
    assign o_revalidate_window_ok = r_o_ok[2];
    assign o_error_window_secs = r_o_secs[3];
    assign o_error_window_ok = r_o_ok[3];
endmodule

// ----- bench/cache_control_header_parser_test.sv -----
// Testbench for the Cache-Control header parser: drives header values byte by byte,
// predicts the parsed directives and checks every result. Depends on ccp_pkg and the RTL.
`timescale 1ns / 100ps

module cache_control_header_parser_test;
    import ccp_pkg::*;

    localparam longint unsigned CycleLimit = 400000;
    localparam logic [63:0] DeltaMax = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last;
        logic       no_byte;
    } t_byte_item;

    typedef struct packed {
        logic [6:0]  flags;
        logic [63:0] max_age;
        logic        max_age_ok;
        logic [63:0] shared_age;
        logic        shared_age_ok;
        logic [63:0] swr;
        logic        swr_ok;
        logic [63:0] sie;
        logic        sie_ok;
    } t_directive_set;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_char_byte;
    logic        i_last;
    logic        i_no_byte;
    logic        o_valid;
    logic        i_ready;
    logic [6:0]  o_directive_flags;
    logic [63:0] o_max_age_secs;
    logic        o_max_age_ok;
    logic [63:0] o_shared_max_age_secs;
    logic        o_shared_max_age_ok;
    logic [63:0] o_revalidate_window_secs;
    logic        o_revalidate_window_ok;
    logic [63:0] o_error_window_secs;
    logic        o_error_window_ok;

    cache_control_header_parser u_top (.*);

    t_byte_item     pending_bytes[$];
    t_directive_set expected_sets[$];
    int             error_count;
    longint unsigned cycle_count;
    bit             stim_done;
    bit             calm_mode;
    int             hold_cycles;
    bit             accepted_seen;

    // Parser state mirror
    bit          sp_quote, sp_esc;
    t_phase      ph;
    int          npos;
    logic [10:0] cands;
    bit          pend_sp;
    t_arg_state  ast;
    t_delta_state dst;
    logic [63:0] acc;
    logic [3:0]  first_seen;
    logic [6:0]  flags_acc;
    logic [63:0] deltas[4];
    logic [3:0]  delta_ok_marks;

    string known[11] = '{"no-store", "no-cache", "must-revalidate", "proxy-revalidate",
        "private", "public", "immutable", "max-age", "s-maxage",
        "stale-while-revalidate", "stale-if-error"};

    // token characters: alphanumerics and ! # $ % & ' * + - . ^ _ backtick | ~
    function automatic bit tchar_class(logic [7:0] c);
        bit r;
        r = (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
            c == 8'h21 || c == 8'h23 || c == 8'h24 || c == 8'h25 || c == 8'h26 ||
            c == 8'h27 || c == 8'h2a || c == 8'h2b || c == 8'h2d || c == 8'h2e ||
            c == 8'h5e || c == 8'h5f || c == 8'h60 || c == 8'h7c || c == 8'h7e;
        return r;
    endfunction

    task automatic clear_directive_state();
        ph = PH_LEAD; npos = 0; cands = '1; pend_sp = 0;
        ast = AS_START; dst = DS_START; acc = 0;
    endtask

    task automatic clear_header_state();
        sp_quote = 0; sp_esc = 0;
        clear_directive_state();
        first_seen = 0; flags_acc = 0; delta_ok_marks = 0;
        for (int k = 0; k < 4; k++) deltas[k] = 0;
    endtask

    function automatic logic [10:0] full_length_names();
        logic [10:0] m;
        m = 0;
        for (int k = 0; k < 11; k++)
            if (cands[k] && known[k].len() == npos) m[k] = 1;
        return m;
    endfunction

    task automatic add_digit(logic [7:0] c);
        logic [63:0] d;
        d = c - "0";
        if (acc > (DeltaMax - d) / 10) acc = DeltaMax;
        else acc = acc * 10 + d;
    endtask

    task automatic step_argument(logic [7:0] c);
        bit ws, dig;
        ws = (c == " " || c == 8'h09);
        dig = (c >= "0" && c <= "9");
        case (ast)
            AS_START: ast = (c == "\"") ? AS_IN : (tchar_class(c) ? AS_TOKEN : AS_BAD);
            AS_TOKEN: ast = tchar_class(c) ? AS_TOKEN : AS_BAD;
            AS_IN: begin
                if (c == "\\") ast = AS_ESC;
                else if (c == "\"") ast = AS_CLOSED;
                else if ((c < 8'h20 && !ws) || c == 8'h7f) ast = AS_BAD;
            end
            AS_ESC: ast = ((c < 8'h21 && !ws) || c == 8'h7f) ? AS_BAD : AS_IN;
            default: ast = AS_BAD;
        endcase
        case (dst)
            DS_START: begin
                if (dig) begin add_digit(c); dst = DS_TOKEN; end
                else dst = (c == "\"") ? DS_OPEN : DS_BAD;
            end
            DS_TOKEN: if (dig) add_digit(c); else dst = DS_BAD;
            DS_OPEN, DS_IN: begin
                if (dig) begin add_digit(c); dst = DS_IN; end
                else if (c == "\\") dst = DS_ESC;
                else if (c == "\"" && dst == DS_IN) dst = DS_CLOSED;
                else dst = DS_BAD;
            end
            DS_ESC: begin
                if (dig) begin add_digit(c); dst = DS_IN; end
                else dst = DS_BAD;
            end
            default: dst = DS_BAD;
        endcase
    endtask

    task automatic feed_directive(logic [7:0] c);
        logic [7:0] lc;
        if (ph == PH_NAME) begin
            if (c == "=") begin
                cands = full_length_names();
                ph = PH_ARG;
            end else begin
                lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
                for (int k = 0; k < 11; k++)
                    if (npos >= known[k].len() || known[k][npos] != lc) cands[k] = 0;
                if (npos < 31) npos++;
            end
        end else begin
            step_argument(c);
        end
    endtask

    task automatic close_directive();
        logic [10:0] match;
        bit has_arg, arg_ok, delta_good;
        if (ph != PH_LEAD) begin
            has_arg = (ph == PH_ARG);
            match = has_arg ? cands : full_length_names();
            arg_ok = (ast == AS_TOKEN || ast == AS_CLOSED);
            delta_good = has_arg && (dst == DS_TOKEN || dst == DS_CLOSED);
            for (int k = 0; k < 7; k++)
                if (match[k] && (!has_arg || ((k == 1 || k == 4) && arg_ok)))
                    flags_acc[k] = 1;
            for (int k = 0; k < 4; k++)
                if (match[k+7] && !first_seen[k]) begin
                    first_seen[k] = 1;
                    if (delta_good) begin
                        deltas[k] = acc;
                        delta_ok_marks[k] = 1;
                    end
                end
        end
        clear_directive_state();
    endtask

    // Advance the predicted parser by one accepted item
    task automatic predict_header_byte(t_byte_item it);
        bit sep, ws;
        t_directive_set r;
        logic [7:0] c;
        c = it.char_byte;
        if (!it.no_byte) begin
            sep = 0;
            if (sp_quote) begin
                if (sp_esc) sp_esc = 0;
                else if (c == "\\") sp_esc = 1;
                else if (c == "\"") sp_quote = 0;
            end else if (c == "\"") sp_quote = 1;
            else if (c == ",") sep = 1;
            ws = (c == " " || c == 8'h09);
            if (sep) close_directive();
            else if (ph == PH_LEAD) begin
                if (!ws) begin ph = PH_NAME; feed_directive(c); end
            end else if (ws) pend_sp = 1;
            else begin
                if (pend_sp) begin
                    pend_sp = 0;
                    if (ph == PH_NAME) cands = 0;
                    else feed_directive(" ");
                end
                feed_directive(c);
            end
        end
        if (it.last) begin
            close_directive();
            r.flags = flags_acc;
            r.max_age = delta_ok_marks[0] ? deltas[0] : 0;
            r.max_age_ok = delta_ok_marks[0];
            r.shared_age = delta_ok_marks[1] ? deltas[1] : 0;
            r.shared_age_ok = delta_ok_marks[1];
            r.swr = delta_ok_marks[2] ? deltas[2] : 0;
            r.swr_ok = delta_ok_marks[2];
            r.sie = delta_ok_marks[3] ? deltas[3] : 0;
            r.sie_ok = delta_ok_marks[3];
            expected_sets.push_back(r);
            clear_header_state();
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
            cycle_count);
    endtask

    // Queue one header value as byte items, last on the final byte
    task automatic queue_text(string s);
        t_byte_item it;
        for (int k = 0; k < s.len(); k++) begin
            it.char_byte = s[k]; it.no_byte = 0; it.last = (k == s.len() - 1);
            pending_bytes.push_back(it);
        end
    endtask

    // Queue one raw byte item, for bytes a string cannot carry
    task automatic queue_raw(logic [7:0] v, bit is_last);
        t_byte_item it;
        it.char_byte = v; it.no_byte = 0; it.last = is_last;
        pending_bytes.push_back(it);
    endtask

    task automatic queue_empty_value();
        t_byte_item it;
        it.char_byte = $urandom; it.no_byte = 1; it.last = 1;
        pending_bytes.push_back(it);
    endtask

    function automatic string random_directive();
        string s, nm;
        int pick;
        nm = known[$urandom_range(0, 10)];
        for (int k = 0; k < nm.len(); k++)
            if ($urandom_range(0, 3) == 0 && nm[k] >= "a" && nm[k] <= "z")
                nm[k] = nm[k] - 8'd32;
        if ($urandom_range(0, 9) == 0) nm = {nm, "x"};
        s = nm;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1: ;
            2, 3, 4: s = {s, "=", $sformatf("%0d", $urandom_range(0, 99999))};
            5: s = {s, "=\"", $sformatf("%0d", $urandom), "\""};
            6: s = {s, "=\"1\\2", "3\""};
            7: s = {s, "=99999999999999999999999"};
            8: s = {s, "=tok-en"};
            default: s = {s, "=", string'(byte'($urandom_range(1, 255)))};
        endcase
        if ($urandom_range(0, 4) == 0) s = {" \t", s, " "};
        return s;
    endfunction

    function automatic string random_header();
        string s;
        int n;
        n = $urandom_range(1, 4);
        s = "";
        for (int k = 0; k < n; k++) begin
            if (k) s = {s, ($urandom_range(0, 7) == 0) ? ",," : ", "};
            s = {s, random_directive()};
        end
        return s;
    endfunction

    function automatic string noise_header();
        string s;
        int n;
        s = "";
        n = $urandom_range(1, 12);
        for (int k = 0; k < n; k++)
            s = {s, string'(byte'($urandom_range(1, 255)))};
        return s;
    endfunction

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Stimulus: directed values, then random ones
    initial begin
        t_byte_item it;
        int total;
        int prior;
        stim_done = 0; error_count = 0;
        clear_header_state();
        queue_empty_value();
        queue_text("no-store, no-cache, must-revalidate, proxy-revalidate");
        queue_text("PRIVATE, Public ,\timmutable, no-cache=\"a\\\"b\", private=x");
        queue_text("max-age=0, s-maxage=18446744073709551615, stale-while-revalidate=\"1\\2\"");
        queue_text("stale-if-error=99999999999999999999, max-age=5");
        queue_text("max-age=x, max-age=3, no-store=1, no cache, ,,");
        queue_text("s-maxage=\"12, stale-if-error=\"\",private=\"a\"b");
        queue_text({"no-cache=\"", string'(8'h01), "\", private=\"", string'(8'h7f),
            "\", max-age = 4"});
        it.char_byte = 8'hff; it.no_byte = 1; it.last = 0; pending_bytes.push_back(it);
        queue_raw(8'h80, 0);
        queue_raw(8'hff, 0);
        queue_raw(8'h00, 0);
        queue_raw("~", 1);
        total = pending_bytes.size();
        while (total < 1650) begin
            if (pending_bytes.size() > 200) @(negedge i_clk);
            else begin
                prior = pending_bytes.size();
                if ($urandom_range(0, 9) == 0) queue_text(noise_header());
                else if ($urandom_range(0, 19) == 0) queue_empty_value();
                else queue_text(random_header());
                total = total + (pending_bytes.size() - prior);
            end
        end
        stim_done = 1;
    end

    // Reset and end of run
    initial begin
        i_rst_n = 0; i_valid = 0; i_char_byte = 0; i_last = 0; i_no_byte = 0; i_ready = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;
        wait (stim_done && pending_bytes.size() == 0 && !i_valid
            && expected_sets.size() == 0);
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_sets.size() == 0)
            $display("PASS cache_control_header_parser");
        else $display("FAIL cache_control_header_parser");
        $finish;
    end

    // Cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("FAIL cache_control_header_parser");
            $finish;
        end
    end
    initial cycle_count = 0;

    // Calm stretch with no idling on either side
    initial calm_mode = 0;
    always @(posedge i_clk) begin
        if (cycle_count == 200) calm_mode <= 1;
        if (cycle_count == 600) calm_mode <= 0;
    end

    // Long receiver hold-off
    initial hold_cycles = 0;
    always @(posedge i_clk) begin
        if (cycle_count == 1000) hold_cycles <= 300;
        else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // Driver: present items at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !accepted_seen) begin
                // hold item until accepted
            end else if (pending_bytes.size() > 0 && (calm_mode || $urandom_range(0, 99) >= 37))
            begin
                i_valid <= 1;
                {i_char_byte, i_last, i_no_byte} <= pending_bytes.pop_front();
            end else begin
                i_valid <= 0;
            end
            i_ready <= (hold_cycles == 0) && (calm_mode || $urandom_range(0, 99) >= 37);
        end
    end

    // Sampled handshake of the input side
    always @(posedge i_clk) begin
        accepted_seen <= i_valid && o_ready;
        if (i_rst_n && i_valid && o_ready)
            predict_header_byte('{i_char_byte, i_last, i_no_byte});
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge i_clk) begin
        t_directive_set w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_sets.size() == 0) report_mismatch("unexpected result", 0, 0);
            else begin
                w = expected_sets.pop_front();
                if (o_directive_flags !== w.flags)
                    report_mismatch("flags", o_directive_flags, w.flags);
                if (o_max_age_secs !== w.max_age)
                    report_mismatch("max_age", o_max_age_secs, w.max_age);
                if (o_max_age_ok !== w.max_age_ok)
                    report_mismatch("max_age_ok", o_max_age_ok, w.max_age_ok);
                if (o_shared_max_age_secs !== w.shared_age)
                    report_mismatch("s_maxage", o_shared_max_age_secs, w.shared_age);
                if (o_shared_max_age_ok !== w.shared_age_ok)
                    report_mismatch("s_maxage_ok", o_shared_max_age_ok, w.shared_age_ok);
                if (o_revalidate_window_secs !== w.swr)
                    report_mismatch("swr", o_revalidate_window_secs, w.swr);
                if (o_revalidate_window_ok !== w.swr_ok)
                    report_mismatch("swr_ok", o_revalidate_window_ok, w.swr_ok);
                if (o_error_window_secs !== w.sie)
                    report_mismatch("sie", o_error_window_secs, w.sie);
                if (o_error_window_ok !== w.sie_ok)
                    report_mismatch("sie_ok", o_error_window_ok, w.sie_ok);
            end
        end
    end

endmodule

// ----- cache_control_header_parser.f -----
design/ccp_pkg.sv
design/cache_control_header_parser.sv
bench/cache_control_header_parser_test.sv
